>>> src/efmd_pkg.sv
package efmd_pkg;

  localparam int unsigned MaxFrameDef  = 64;
  localparam int unsigned PayloadDepth = 15;
  localparam int unsigned LenW         = 7;
  localparam int unsigned ResultW      = 134;
  localparam int unsigned TdataW       = ((ResultW + 7) / 8) * 8;

  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChCaret   = 8'h5E;
  localparam logic [7:0] ChEscM    = 8'h4D;
  localparam logic [7:0] ChEscQ    = 8'h51;
  localparam logic [7:0] ChEscS    = 8'h53;
  localparam logic [7:0] ChXon     = 8'h11;
  localparam logic [7:0] ChXoff    = 8'h13;
  localparam logic [7:0] TypeMotion  = 8'h44;
  localparam logic [7:0] TypeButtons = 8'h2E;
  localparam logic [7:0] TypeKey     = 8'h4B;

  localparam logic [1:0] KindMotion  = 2'd0;
  localparam logic [1:0] KindButtons = 2'd1;
  localparam logic [1:0] KindKey     = 2'd2;
  localparam logic [1:0] KindOther   = 2'd3;

  typedef logic [PayloadDepth-1:0][7:0] payload_t;

  // first member lands in the highest bits, so frame_kind sits at bit 0
  typedef struct packed {
    logic               overflow;
    logic [LenW-1:0]    frame_length;
    logic signed [15:0] rot_z;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_x;
    logic signed [15:0] trans_z;
    logic signed [15:0] trans_y;
    logic signed [15:0] trans_x;
    logic [15:0]        period;
    logic [11:0]        button_bits;
    logic [1:0]         frame_kind;
  } result_t;

  function automatic logic [7:0] unescape(input logic [7:0] b);
    logic [7:0] r;
    unique case (b)
      ChEscM:  r = ChCr;
      ChEscQ:  r = ChXon;
      ChEscS:  r = ChXoff;
      default: r = b;
    endcase
    return r;
  endfunction

endpackage

>>> src/efmd_decode.sv
module efmd_decode
  import efmd_pkg::*;
(
  input  payload_t        payload,
  input  logic [LenW-1:0] frame_length,
  input  logic            overflow,
  output result_t         result
);

  logic [1:0] kind;
  logic [7:0] b1;
  logic [7:0] b2;
  logic       motion;

  assign b1     = payload[1];
  assign b2     = payload[2];
  assign motion = (kind == KindMotion);

  always_comb begin
    unique case (payload[0])
      TypeMotion:  kind = KindMotion;
      TypeButtons: kind = KindButtons;
      TypeKey:     kind = KindKey;
      default:     kind = KindOther;
    endcase
  end

  always_comb begin
    result              = '0;
    result.frame_kind   = kind;
    result.frame_length = frame_length;
    result.overflow     = overflow;
    if (kind == KindButtons) begin
      result.button_bits = {b1[1:0], b2[7], b2[5:0], b1[4:2]};
    end
    if (motion) begin
      result.period  = {payload[1],  payload[2]};
      result.trans_x = {payload[3],  payload[4]};
      result.trans_y = {payload[5],  payload[6]};
      result.trans_z = {payload[7],  payload[8]};
      result.rot_x   = {payload[9],  payload[10]};
      result.rot_y   = {payload[11], payload[12]};
      result.rot_z   = {payload[13], payload[14]};
    end
  end

endmodule

>>> src/escaped_frame_motion_decoder.sv
// A result appears on out_tvalid in the cycle after the transfer of the ending CR byte.
// Throughput: one byte per cycle while in_tready is high; frame state and the result register update in one pass.
// in_tready drops only while a finished result waits and out_tready is low.
// Reset (rst_n low, synchronous) clears escape, position, overflow, stored bytes
// and the output valid.
module escaped_frame_motion_decoder
  import efmd_pkg::*;
#(
  parameter int unsigned MAX_FRAME = MaxFrameDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // rx_byte
  output logic              out_tvalid,
  input  logic              out_tready,
  // frame_kind, button_bits, period, trans_x, trans_y, trans_z, rot_x, rot_y, rot_z,
  // frame_length, overflow, zero pad
  output logic [TdataW-1:0] out_tdata
);

  localparam int unsigned PosW = $clog2(MAX_FRAME + 1);
  localparam logic [PosW-1:0] PosMax = PosW'(MAX_FRAME);
  localparam logic [PosW-1:0] PosDepth = PosW'(PayloadDepth);

  logic            esc_r,  esc_nxt;
  logic [PosW-1:0] pos_r,  pos_nxt;
  logic            ovf_r,  ovf_nxt;
  payload_t        pay_r,  pay_nxt;
  logic            ovalid_r, ovalid_nxt;
  result_t         res_r,  res_nxt;

  logic            accept;
  logic            is_cr;
  logic            store;
  logic [7:0]      store_byte;
  logic [PosW+LenW-1:0] pos_ext;
  result_t         dec_res;

  assign in_tready  = !ovalid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign is_cr      = (in_tdata == ChCr);
  assign pos_ext    = {{LenW{1'b0}}, pos_r};
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {{(TdataW - ResultW){1'b0}}, res_r};

  efmd_decode u_decode (
    .payload      (pay_r),
    .frame_length (pos_ext[LenW-1:0]),
    .overflow     (ovf_r),
    .result       (dec_res)
  );

  always_comb begin
    esc_nxt    = esc_r;
    pos_nxt    = pos_r;
    ovf_nxt    = ovf_r;
    pay_nxt    = pay_r;
    ovalid_nxt = ovalid_r && !out_tready;
    res_nxt    = res_r;
    store      = 1'b0;
    store_byte = in_tdata;
    if (accept) begin
      if (is_cr) begin
        ovalid_nxt = 1'b1;
        res_nxt    = dec_res;
        esc_nxt    = 1'b0;
        pos_nxt    = '0;
        ovf_nxt    = 1'b0;
        pay_nxt    = '0;
      end else if (esc_r) begin
        esc_nxt    = 1'b0;
        store      = 1'b1;
        store_byte = unescape(in_tdata);
      end else if (in_tdata == ChCaret) begin
        esc_nxt = 1'b1;
      end else begin
        store = 1'b1;
      end
    end
    if (store) begin
      if (pos_r < PosMax) begin
        pos_nxt = pos_r + 1'b1;
        if (pos_r < PosDepth) begin
          for (int i = 0; i < PayloadDepth; i++) begin
            if (pos_r == PosW'(i)) pay_nxt[i] = store_byte;
          end
        end
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r    <= 1'b0;
      pos_r    <= '0;
      ovf_r    <= 1'b0;
      pay_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      esc_r    <= esc_nxt;
      pos_r    <= pos_nxt;
      ovf_r    <= ovf_nxt;
      pay_r    <= pay_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

>>> src/efmd_chk.sv
module efmd_chk
  import efmd_pkg::*;
#(
  parameter int unsigned MAX_FRAME = MaxFrameDef
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic [7:0]        in_tdata,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [TdataW-1:0] out_tdata
);

  localparam logic [LenW-1:0] LenAtMax = LenW'(MAX_FRAME % (1 << LenW));

  result_t res;
  assign res = result_t'(out_tdata[ResultW-1:0]);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  a_new_from_cr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !$past(out_tvalid && !out_tready)) |->
      $past(in_tvalid && in_tready && in_tdata == ChCr))
    else $error("result without an ending CR transfer");

  a_ovf_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.overflow |-> res.frame_length == LenAtMax)
    else $error("overflow flagged below the frame limit");

  a_kind_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      (res.frame_kind == KindMotion || out_tdata[125:14] == '0) &&
      (res.frame_kind == KindButtons || res.button_bits == '0))
    else $error("fields set for a frame of another kind");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind escaped_frame_motion_decoder efmd_chk #(.MAX_FRAME(MAX_FRAME)) u_efmd_chk (.*);
